// File: rtl/nsc_pkg.sv
// Shared types, character codes and helpers for the NMEA sentence checker.
`timescale 1ns / 1ps

package nsc_pkg;

    localparam int unsigned FIELD_W   = 7;
    localparam int unsigned CODE_W    = 24;
    localparam int unsigned POS_W     = 3;
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;

    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;

    // digit lookup returns this value for a non-hex byte
    localparam logic [4:0] HEX_NONE   = 5'd16;

    localparam logic [POS_W-1:0]   POS_MAX        = 3'd7;
    localparam logic [POS_W-1:0]   POS_ID_FIRST   = 3'd3;
    localparam logic [POS_W-1:0]   POS_ID_LAST    = 3'd5;
    localparam logic [POS_W-1:0]   POS_MIN_LEN    = 3'd6;
    localparam logic [1:0]         AFTER_STAR_MAX = 2'd2;
    localparam logic [FIELD_W-1:0] FIELD_CNT_MAX  = 7'd127;
    localparam logic [FIELD_W-1:0] MAX_FIELDS_RST = 7'd20;

    // register index of max_fields (byte address bit 2)
    localparam logic REG_MAX_FIELDS = 1'b0;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_line;
    } t_nsc_in;

    typedef struct packed {
        logic               checksum_ok;
        logic               id_valid;
        logic [CODE_W-1:0]  sentence_code;
        logic [FIELD_W-1:0] field_total;
    } t_nsc_out;

    typedef struct packed {
        logic [POS_W-1:0]   byte_position;
        logic               leads_with_dollar;
        logic               star_found;
        logic [7:0]         running_xor;
        logic [1:0]         bytes_after_star;
        logic               hex_run_open;
        logic [7:0]         stated_sum;
        logic [CODE_W-1:0]  id_bytes;
        logic               id_letters_good;
        logic               body_ended;
        logic [FIELD_W-1:0] field_counter;
    } t_nsc_state;

    localparam t_nsc_state STATE_CLEAR = '{
        byte_position:     '0,
        leads_with_dollar: 1'b0,
        star_found:        1'b0,
        running_xor:       '0,
        bytes_after_star:  '0,
        hex_run_open:      1'b1,
        stated_sum:        '0,
        id_bytes:          '0,
        id_letters_good:   1'b1,
        body_ended:        1'b0,
        field_counter:     7'd1
    };

    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] d;
        d = HEX_NONE;
        if (b inside {[8'h30:8'h39]}) begin
            d = {1'b0, b[3:0]};
        end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            d = 5'(b[2:0]) + 5'd9;
        end
        return d;
    endfunction

endpackage

// File: rtl/nsc_track.sv
// Per-sentence tracking state and its one-byte update.
`timescale 1ns / 1ps

module nsc_track (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  nsc_pkg::t_nsc_in    i_item,
    output nsc_pkg::t_nsc_state o_next
);
    import nsc_pkg::*;

    t_nsc_state r_state;
    t_nsc_state n_state;
    logic [7:0] b;
    logic [4:0] d;

    assign b = i_item.char_byte;
    assign d = hex_value(b);

    always_comb begin
        n_state = r_state;

        // checksum: XOR up to first '*', then hex digits after it
        if (!r_state.star_found) begin
            if (b == CH_STAR) begin
                n_state.star_found = 1'b1;
            end else if (r_state.byte_position != '0) begin
                n_state.running_xor = r_state.running_xor ^ b;
            end
        end else begin
            if (r_state.bytes_after_star < AFTER_STAR_MAX) begin
                n_state.bytes_after_star = r_state.bytes_after_star + 2'd1;
            end
            if (r_state.hex_run_open) begin
                if (d != HEX_NONE) begin
                    n_state.stated_sum = {r_state.stated_sum[3:0], d[3:0]};
                end else begin
                    n_state.hex_run_open = 1'b0;
                end
            end
        end

        // sentence ID
        if (r_state.byte_position == '0) begin
            n_state.leads_with_dollar = (b == CH_DOLLAR);
        end
        if (r_state.byte_position >= POS_ID_FIRST && r_state.byte_position <= POS_ID_LAST) begin
            n_state.id_bytes = {r_state.id_bytes[CODE_W-9:0], b};
            if (b < CH_UPPER_A || b > CH_UPPER_Z) begin
                n_state.id_letters_good = 1'b0;
            end
        end

        // field count up to first '*', CR or LF
        if (!r_state.body_ended) begin
            if (b == CH_STAR || b == CH_CR || b == CH_LF) begin
                n_state.body_ended = 1'b1;
            end else if (b == CH_COMMA && r_state.field_counter < FIELD_CNT_MAX) begin
                n_state.field_counter = r_state.field_counter + 7'd1;
            end
        end

        if (r_state.byte_position < POS_MAX) begin
            n_state.byte_position = r_state.byte_position + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_CLEAR;
        end else if (i_accept) begin
            r_state <= i_item.end_of_line ? STATE_CLEAR : n_state;
        end
    end

    assign o_next = n_state;

endmodule

// File: rtl/nsc_result.sv
// Sentence verdict logic and the output register.
`timescale 1ns / 1ps

module nsc_result (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  nsc_pkg::t_nsc_state               i_state,
    input  logic [nsc_pkg::FIELD_W-1:0]       i_max_fields,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output nsc_pkg::t_nsc_out                 o_out_item
);
    import nsc_pkg::*;

    t_nsc_out           n_item;
    t_nsc_out           r_item;
    logic               r_valid;
    logic               id_ok;
    logic [FIELD_W-1:0] limit;

    always_comb begin
        id_ok = i_state.leads_with_dollar && (i_state.byte_position >= POS_MIN_LEN);
        limit = (i_max_fields == '0) ? 7'd1 : i_max_fields;

        n_item.checksum_ok   = !i_state.star_found
                            || (i_state.bytes_after_star < AFTER_STAR_MAX)
                            || (i_state.running_xor == i_state.stated_sum);
        n_item.id_valid      = id_ok && i_state.id_letters_good;
        n_item.sentence_code = id_ok ? i_state.id_bytes : '0;
        n_item.field_total   = (i_state.field_counter < limit) ? i_state.field_counter : limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= n_item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

// File: rtl/nmea_sentence_checker_unit.sv
// Top level of the NMEA 0183 sentence checker: channels, config port, submodules.
// The result appears in the output register the cycle after the final byte is accepted.
// Throughput: one byte per cycle; the per-byte update is XOR, compares and small counters.
// The input stalls only while a finished result is held and the output side stalls.
// Reset (synchronous, active low) clears the sentence state and the output valid,
// and sets max_fields to 20.
`timescale 1ns / 1ps

module nmea_sentence_checker_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // byte input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  nsc_pkg::t_nsc_in                  i_in_item,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output nsc_pkg::t_nsc_out                 o_out_item,
    // APB config port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nsc_pkg::PADDR_W-1:0]       paddr,
    input  logic [nsc_pkg::PDATA_W-1:0]       pwdata,
    output logic [nsc_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);
    import nsc_pkg::*;

    logic               accept;
    logic               cfg_write;
    logic [FIELD_W-1:0] r_max_fields;
    t_nsc_state         next_state;

    // Only a held result that the far side refuses blocks new bytes;
    // otherwise the output register is free or drains this same cycle.
    assign o_in_stall = o_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    // Config: one register at byte address 0, decoded on address bit 2.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_FIELDS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_fields <= MAX_FIELDS_RST;
        end else if (cfg_write) begin
            r_max_fields <= pwdata[FIELD_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_MAX_FIELDS) ? PDATA_W'(r_max_fields) : '0;

    // Sentence state: updated per accepted byte, cleared on end of line.
    nsc_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_item  (i_in_item),
        .o_next  (next_state)
    );

    // Verdict from the post-byte state, loaded on the final byte.
    nsc_result u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept && i_in_item.end_of_line),
        .i_state     (next_state),
        .i_max_fields(r_max_fields),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// File: rtl/nsc_checker.sv
// Port-level checks for the sentence checker and their bind to the top level.
`timescale 1ns / 1ps

module nsc_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input nsc_pkg::t_nsc_in      i_in_item,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input nsc_pkg::t_nsc_out     o_out_item
);
    import nsc_pkg::*;

    // held result must not change while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // final byte always yields a result next cycle
    a_eol_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_item.end_of_line |=> o_out_valid)
        else $error("no result after final byte");

    // mid-sentence byte never invents a result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_in_item.end_of_line && !o_out_valid
        |=> !o_out_valid)
        else $error("result without final byte");

    a_field_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.field_total != '0)
        else $error("field total is zero");

    // a valid ID has an uppercase leading letter
    a_id_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.id_valid
        |-> o_out_item.sentence_code[23:16] >= CH_UPPER_A
            && o_out_item.sentence_code[23:16] <= CH_UPPER_Z)
        else $error("valid ID with bad letter");

endmodule

bind nmea_sentence_checker_unit nsc_checker u_nsc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in_item  (i_in_item),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_item (o_out_item)
);

// File: bench/tb_nmea_sentence_checker_unit.sv
// Self-checking testbench for the NMEA sentence checker: byte stream in, verdicts out.
`timescale 1ns / 1ps

module tb_nmea_sentence_checker_unit;
    import nsc_pkg::*;

    // stimulus stops on these; the run itself ends on the checks or the cycle limit
    localparam int RANDOM_BYTES  = 100;
    localparam int RANDOM_LINES  = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;

    // max_fields is register 0, at byte address 0
    localparam logic [PADDR_W-1:0] ADDR_MAX_FIELDS = {REG_MAX_FIELDS, 2'b00};

    localparam string HEX_UPPER   = "0123456789ABCDEF";
    localparam string HEX_LOWER   = "0123456789abcdef";
    localparam string FIELD_CHARS = "0123456789.ABCDEFNSEW-";

    // flaws injected into otherwise well-formed sentences
    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_ID,
        FLAW_WRONG_SUM,
        FLAW_LOWER_HEX,
        FLAW_ONE_DIGIT,
        FLAW_NO_STAR,
        FLAW_TRUNCATED,
        FLAW_NO_DOLLAR,
        FLAW_TRAILING
    } flaw_e;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_nsc_in              i_in_item = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_nsc_out             o_out_item;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    nmea_sentence_checker_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Verdict predictor: per-sentence state, cleared after every final byte
    // ------------------------------------------------------------------
    typedef struct packed {
        bit [2:0]  pos;         // saturates at 7
        bit        dollar;
        bit        star;
        bit [7:0]  xsum;
        bit [1:0]  after_star;  // saturates at 2
        bit        hex_open;
        bit [7:0]  stated;
        bit [23:0] code;
        bit        upper_ok;
        bit        body_done;
        bit [6:0]  fields;      // saturates at 127
    } line_state_t;

    localparam line_state_t LINE_FRESH = '{
        pos: '0, dollar: 1'b0, star: 1'b0, xsum: '0, after_star: '0,
        hex_open: 1'b1, stated: '0, code: '0, upper_ok: 1'b1,
        body_done: 1'b0, fields: 7'd1
    };

    line_state_t cur_line = LINE_FRESH;
    bit [6:0]    field_cap = MAX_FIELDS_RST;
    t_nsc_out    pending_verdicts[$];

    function automatic int hex_digit_value(input bit [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "A" && c <= "F") return c - "A" + 10;
        if (c >= "a" && c <= "f") return c - "a" + 10;
        return -1;
    endfunction

    task automatic predict_char(input t_nsc_in it, output bit done, output t_nsc_out v);
        bit [7:0] c;
        int       d;
        bit       id_ok;
        bit [6:0] cap;
        c = it.char_byte;
        v = '0;
        // checksum: xor up to the first star, then hex digits right after it
        if (!cur_line.star) begin
            if (c == CH_STAR) cur_line.star = 1'b1;
            else if (cur_line.pos != 0) cur_line.xsum ^= c;
        end else begin
            if (cur_line.after_star < 2) cur_line.after_star++;
            if (cur_line.hex_open) begin
                d = hex_digit_value(c);
                if (d >= 0) cur_line.stated = {cur_line.stated[3:0], 4'(d)};
                else cur_line.hex_open = 1'b0;
            end
        end
        // sentence ID
        if (cur_line.pos == 0) cur_line.dollar = (c == CH_DOLLAR);
        if (cur_line.pos >= 3 && cur_line.pos <= 5) begin
            cur_line.code = {cur_line.code[15:0], c};
            if (c < CH_UPPER_A || c > CH_UPPER_Z) cur_line.upper_ok = 1'b0;
        end
        // field count stops at star, CR or LF
        if (!cur_line.body_done) begin
            if (c == CH_STAR || c == CH_CR || c == CH_LF) cur_line.body_done = 1'b1;
            else if (c == CH_COMMA && cur_line.fields != 7'd127) cur_line.fields++;
        end
        if (cur_line.pos != 3'd7) cur_line.pos++;

        done = it.end_of_line;
        if (done) begin
            id_ok = cur_line.dollar && cur_line.pos >= 6;
            cap = (field_cap == 0) ? 7'd1 : field_cap;
            v.checksum_ok   = !cur_line.star || cur_line.after_star < 2 ||
                              cur_line.xsum == cur_line.stated;
            v.id_valid      = id_ok && cur_line.upper_ok;
            v.sentence_code = id_ok ? cur_line.code : '0;
            v.field_total   = (cur_line.fields < cap) ? cur_line.fields : cap;
            cur_line = LINE_FRESH;
        end
    endtask

    // ------------------------------------------------------------------
    // Verdict checker
    // ------------------------------------------------------------------
    int       failures = 0;
    t_nsc_out want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                $error("verdict with none expected: %h", o_out_item);
                failures++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_out_item.checksum_ok !== want.checksum_ok) begin
                    $error("checksum_ok: expected %0d, got %0d",
                           want.checksum_ok, o_out_item.checksum_ok);
                    failures++;
                end
                if (o_out_item.id_valid !== want.id_valid) begin
                    $error("id_valid: expected %0d, got %0d",
                           want.id_valid, o_out_item.id_valid);
                    failures++;
                end
                if (o_out_item.sentence_code !== want.sentence_code) begin
                    $error("sentence_code: expected %h, got %h",
                           want.sentence_code, o_out_item.sentence_code);
                    failures++;
                end
                if (o_out_item.field_total !== want.field_total) begin
                    $error("field_total: expected %0d, got %0d",
                           want.field_total, o_out_item.field_total);
                    failures++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall runs, plus an on-demand long hold-off
    // ------------------------------------------------------------------
    int stall_pct = 0;
    int run_left = 0;
    bit run_stalled = 1'b0;
    int hold_len = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_pct == 0) begin
            i_out_stall <= 1'b0;
        end else begin
            if (run_left == 0) begin
                run_stalled = ($urandom_range(0, 99) < stall_pct);
                run_left = $urandom_range(1, 6);
            end
            run_left--;
            i_out_stall <= run_stalled;
        end
    end

    // hard stop if the handshakes hang
    int unsigned cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_nmea_sentence_checker_unit failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender: one byte per handshake, bursts with random gaps
    // ------------------------------------------------------------------
    bit       gaps_on = 1'b1;
    int       burst_left = 0;
    int       bytes_sent = 0;
    bit [7:0] line_buf[$];

    // called in the time step of a rising edge
    task automatic send_item(input bit [7:0] c, input bit eol);
        t_nsc_in  it;
        bit       done;
        t_nsc_out v;
        it.char_byte = c;
        it.end_of_line = eol;
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_char(it, done, v);
        if (done) pending_verdicts.push_back(v);
        bytes_sent++;
        if (burst_left > 0) burst_left--;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // end flag goes on the last byte of the buffer
    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++) begin
            send_item(line_buf[i], i == line_buf.size() - 1);
        end
        line_buf.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    // appends '*' and one or two hex digits of (XOR of bytes after byte 0) ^ flip
    task automatic push_checksum(input bit lower, input bit one_digit, input bit [7:0] flip);
        bit [7:0] sum;
        string    digits;
        sum = 8'h00;
        for (int i = 1; i < line_buf.size(); i++) sum ^= line_buf[i];
        sum ^= flip;
        digits = lower ? HEX_LOWER : HEX_UPPER;
        line_buf.push_back(CH_STAR);
        line_buf.push_back(digits[sum[7:4]]);
        if (!one_digit) line_buf.push_back(digits[sum[3:0]]);
    endtask

    task automatic send_text(input string s, input bit with_sum);
        push_text(s);
        if (with_sum) push_checksum(1'b0, 1'b0, 8'h00);
        send_line();
    endtask

    task automatic build_sentence(input flaw_e flaw);
        int nf;
        int len;
        if (flaw == FLAW_NO_DOLLAR) line_buf.push_back(8'($urandom_range(1, 255)));
        else line_buf.push_back(CH_DOLLAR);
        repeat (5) line_buf.push_back(8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)));
        if (flaw == FLAW_BAD_ID) line_buf[$urandom_range(3, 5)] = 8'($urandom_range(1, 255));
        // mostly a handful of fields, now and then 20 to 70 of them
        nf = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 8);
        repeat (nf) begin
            line_buf.push_back(CH_COMMA);
            len = $urandom_range(0, 6);
            repeat (len) line_buf.push_back(FIELD_CHARS[$urandom_range(0, FIELD_CHARS.len() - 1)]);
        end
        if (flaw != FLAW_NO_STAR) begin
            push_checksum(flaw == FLAW_LOWER_HEX, flaw == FLAW_ONE_DIGIT,
                          flaw == FLAW_WRONG_SUM ? 8'($urandom_range(1, 255)) : 8'h00);
        end
        if ($urandom_range(0, 1)) begin
            line_buf.push_back(CH_CR);
            line_buf.push_back(CH_LF);
        end
        if (flaw == FLAW_TRUNCATED) begin
            len = $urandom_range(1, line_buf.size());
            while (line_buf.size() > len) void'(line_buf.pop_back());
        end
        if (flaw == FLAW_TRAILING) begin
            repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    task automatic build_noise();
        repeat ($urandom_range(1, 10)) line_buf.push_back(8'($urandom_range(1, 255)));
    endtask

    // stop offering, wait for every verdict, then let the pipeline settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup then access; upper data bits are don't-care
    task automatic write_max_fields(input bit [6:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_MAX_FIELDS;
        pwdata <= {25'($urandom), v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        field_cap = v;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_lines();
        gaps_on = 1'b1;
        stall_pct = 30;
        // one-byte lines: byte extremes and a zero byte
        send_item(8'h01, 1'b1);
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b1);
        send_text("*00", 1'b0);            // star at byte 0
        send_text("$GPRMC", 1'b0);         // exactly six bytes
        send_text("$GPrm", 1'b0);          // too short for an ID
        send_text("$GPGGA,1,,", 1'b1);     // good sum
        send_text("$GPZDA*00", 1'b0);      // wrong sum
        send_text("$GPab9,x\r\n", 1'b0);   // bad ID letters, CR ends fields
        send_text("A,B*1g", 1'b0);         // digit run broken by a non-hex byte
        send_text("$*1234", 1'b0);         // long digit run, low byte kept
        send_text("$GPVTG,*7", 1'b0);      // only one byte after star
        send_text("$GPVTG,*a5", 1'b0);     // lowercase hex
        drain_results();
    endtask

    task automatic test_field_limit();
        bit [6:0] caps[5];
        caps = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd20};
        gaps_on = 1'b0;
        stall_pct = 0;
        foreach (caps[k]) begin
            write_max_fields(caps[k]);
            // from no commas up to the limit, and past it for the small caps
            if (caps[k] != 7'd127) begin
                for (int n = 0; n <= caps[k] + 1; n += (caps[k] > 2 ? caps[k] - 1 : 1)) begin
                    push_text("$GPGSV");
                    repeat (n) line_buf.push_back(CH_COMMA);
                    send_line();
                end
            end else begin
                // counter itself saturates
                push_text("$GPGSV");
                repeat (130) line_buf.push_back(CH_COMMA);
                send_line();
            end
            drain_results();
            gaps_on = 1'b1;
            stall_pct = 40;
        end
    endtask

    // receiver holds off while sentences keep coming: the held verdict stalls the input
    task automatic test_backpressure();
        gaps_on = 1'b0;
        stall_pct = 0;
        hold_len = 300;
        hold_seq++;
        repeat (3) begin
            build_sentence(FLAW_NONE);
            send_line();
        end
        drain_results();
    endtask

    task automatic test_random_traffic();
        int start_bytes;
        int lines;
        int pick;
        start_bytes = bytes_sent;
        lines = 0;
        while (bytes_sent - start_bytes < RANDOM_BYTES || lines < RANDOM_LINES) begin
            if (lines % 16 == 0) begin
                if (lines == 16) begin
                    gaps_on = 1'b0;
                    stall_pct = 0;
                end else begin
                    gaps_on = ($urandom_range(0, 2) != 0);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 20;
                        2: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
            end
            if (lines % 48 == 47) begin
                drain_results();
                write_max_fields(7'($urandom_range(1, 64)));
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) build_sentence(FLAW_NONE);
            else if (pick < 90) build_sentence(flaw_e'($urandom_range(FLAW_BAD_ID, FLAW_TRAILING)));
            else build_noise();
            send_line();
            lines++;
        end
        drain_results();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_lines();
        test_field_limit();
        test_backpressure();
        test_random_traffic();

        repeat (8) @(posedge i_clk);
        if (pending_verdicts.size() != 0) begin
            $error("%0d verdicts never arrived", pending_verdicts.size());
            failures++;
        end
        if (failures == 0) begin
            $display("tb_nmea_sentence_checker_unit passed");
        end else begin
            $display("tb_nmea_sentence_checker_unit failed");
        end
        $finish;
    end

endmodule
